>>> hdl/ptl_pkg.sv
// ============================================================================
// ptl_pkg: shared types and constants of the proportional text layout block
// Request kinds, character codes, queue entry layout and queue status.
// ============================================================================
package ptl_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int QUSE_BITS   = QCNT_BITS + 1;

   localparam logic [7:0] END_CODE  = 8'd0;
   localparam logic [7:0] LF_CODE   = 8'd10;
   localparam logic [7:0] SKIP_CODE = 8'h23;
   localparam logic [7:0] BOLD_CODE = 8'h24;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_START = 2'd1,
      REQ_CHAR  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_NEWLINE = 2'd1,
      OP_GLYPH   = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type                  kind;
      logic [7:0]                   code;
      logic                         bold;
      logic [7:0]                   width;
      logic signed [FIELD_BITS-1:0] org_x;
      logic signed [FIELD_BITS-1:0] org_y;
      logic signed [FIELD_BITS-1:0] limit;
   } q_entry_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 empty;
      logic                 full;
   } q_status_type;

endpackage

>>> hdl/ptl_ram.sv
// ============================================================================
// ptl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module ptl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ptl_front.sv
// ============================================================================
// ptl_front: request intake and classification
// Decodes requests, keeps the string state, owns the glyph width table and
// hands classified operations with their widths to the queue.
// ============================================================================
module ptl_front #(
   parameter int GLYPH_COUNT      = 256,
   parameter int MAX_STRING_CHARS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  ptl_pkg::q_status_type q_status,
   output logic                  q_push,
   output ptl_pkg::q_entry_type  q_entry
);

   localparam int IDX_BITS = $clog2(GLYPH_COUNT);
   localparam int CNT_BITS = $clog2(MAX_STRING_CHARS + 1);
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);
   localparam logic [CNT_BITS-1:0] CHAR_LIMIT = CNT_BITS'(MAX_STRING_CHARS);

   ptl_pkg::req_kind_type req_kind;
   logic [7:0]            req_code;
   logic                  req_fire;
   logic                  in_range;
   logic [IDX_BITS-1:0]   tbl_addr;
   logic                  wr_en;
   logic [7:0]            ram_rd;
   logic [ptl_pkg::QUSE_BITS-1:0] used;

   logic [GLYPH_COUNT-1:0] valid_ff, valid_in;
   logic                   ended_ff, ended_in;
   logic [CNT_BITS-1:0]    chars_ff, chars_in, chars_inc;
   logic                   bold_ff, bold_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_hit_ff, s1_hit_in;
   ptl_pkg::q_entry_type   s1_entry_ff, s1_entry_in;

   assign req_kind  = ptl_pkg::req_kind_type'(req_tuser);
   assign req_code  = req_tdata[7:0];
   assign used      = ptl_pkg::QUSE_BITS'(q_status.count) + ptl_pkg::QUSE_BITS'(s1_valid_ff);
   assign req_tready = used < ptl_pkg::QUSE_BITS'(ptl_pkg::QUEUE_DEPTH);
   assign req_fire  = req_tvalid && req_tready;
   assign in_range  = {1'b0, req_code} < GLYPH_LIMIT;
   assign tbl_addr  = req_code[IDX_BITS-1:0];
   assign wr_en     = req_fire && (req_kind == ptl_pkg::REQ_WRITE) && in_range;
   assign chars_inc = chars_ff + 1'b1;

   ptl_ram #(
      .WIDTH(8),
      .DEPTH(GLYPH_COUNT)
   ) u_width_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tbl_addr),
      .wr_data(req_tdata[15:8]),
      .rd_en  (req_fire),
      .rd_addr(tbl_addr),
      .rd_data(ram_rd)
   );

   always_comb begin
      valid_in    = valid_ff;
      ended_in    = ended_ff;
      chars_in    = chars_ff;
      bold_in     = bold_ff;
      s1_valid_in = 1'b0;
      s1_hit_in   = s1_hit_ff;
      s1_entry_in = s1_entry_ff;
      if (wr_en) begin
         valid_in[tbl_addr] = 1'b1;
      end
      if (req_fire) begin
         s1_hit_in         = in_range && valid_ff[tbl_addr];
         s1_entry_in.kind  = ptl_pkg::OP_GLYPH;
         s1_entry_in.code  = req_code;
         s1_entry_in.bold  = bold_ff;
         s1_entry_in.width = '0;
         s1_entry_in.org_x = req_tdata[31:16];
         s1_entry_in.org_y = req_tdata[47:32];
         s1_entry_in.limit = req_tdata[63:48];
         unique case (req_kind)
            ptl_pkg::REQ_WRITE: begin
            end
            ptl_pkg::REQ_START: begin
               ended_in         = 1'b0;
               chars_in         = '0;
               bold_in          = 1'b0;
               s1_entry_in.kind = ptl_pkg::OP_START;
               s1_valid_in      = 1'b1;
            end
            ptl_pkg::REQ_CHAR: begin
               if (!ended_ff) begin
                  if (req_code == ptl_pkg::END_CODE) begin
                     ended_in = 1'b1;
                  end else begin
                     chars_in = chars_inc;
                     if (chars_inc >= CHAR_LIMIT) begin
                        ended_in = 1'b1;
                     end
                     case (req_code)
                        ptl_pkg::LF_CODE: begin
                           s1_entry_in.kind = ptl_pkg::OP_NEWLINE;
                           s1_valid_in      = 1'b1;
                        end
                        ptl_pkg::BOLD_CODE: begin
                           bold_in = !bold_ff;
                        end
                        ptl_pkg::SKIP_CODE: begin
                        end
                        default: begin
                           s1_valid_in = 1'b1;
                        end
                     endcase
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ended_ff    <= 1'b1;
         chars_ff    <= '0;
         bold_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         ended_ff    <= ended_in;
         chars_ff    <= chars_in;
         bold_ff     <= bold_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_hit_ff   <= s1_hit_in;
      s1_entry_ff <= s1_entry_in;
   end

   always_comb begin
      q_entry       = s1_entry_ff;
      q_entry.width = s1_hit_ff ? ram_rd : 8'd0;
   end

   assign q_push = s1_valid_ff;

endmodule

>>> hdl/ptl_queue.sv
// ============================================================================
// ptl_queue: operation queue between the front and back parts
// A short first-in first-out buffer of classified operations.
// ============================================================================
module ptl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptl_pkg::q_entry_type  push_entry,
   input  logic                  pop,
   output ptl_pkg::q_entry_type  head,
   output ptl_pkg::q_status_type status
);

   ptl_pkg::q_entry_type mem_ff [ptl_pkg::QUEUE_DEPTH];
   logic [ptl_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptl_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptl_pkg::QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == ptl_pkg::QCNT_BITS'(ptl_pkg::QUEUE_DEPTH);

endmodule

>>> hdl/ptl_back.sv
// ============================================================================
// ptl_back: cursor tracking and glyph placement
// Executes queued operations, keeps the cursor and drives the result register.
// ============================================================================
module ptl_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  ptl_pkg::q_entry_type  head,
   input  ptl_pkg::q_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int C = COORD_BITS;
   localparam int E = COORD_BITS + 2;

   logic [7:0]             lh_ff, lh_in;
   logic signed [C-1:0]    cx_ff, cx_in;
   logic signed [C-1:0]    cy_ff, cy_in;
   logic signed [C-1:0]    lx_ff, lx_in;
   logic signed [C-1:0]    lim_ff, lim_in;
   logic                   pend_ff, pend_in;
   logic signed [C-1:0]    pend_x_ff, pend_x_in;
   logic signed [C-1:0]    pend_y_ff, pend_y_in;
   logic [7:0]             pend_code_ff, pend_code_in;
   logic                   rv_ff, rv_in;
   logic [7:0]             rcode_ff, rcode_in;
   logic [15:0]            rx_ff, rx_in;
   logic [15:0]            ry_ff, ry_in;
   logic                   rlast_ff, rlast_in;

   logic                   out_ready;
   logic signed [C-1:0]    h_ox, h_oy, h_lim;
   logic signed [E-1:0]    cx_e, w_e, lim_e, reach;
   logic                   wrap;
   logic signed [C-1:0]    px, py;

   assign out_ready = !rv_ff || rsp_tready;
   assign h_ox  = C'({{16{head.org_x[15]}}, head.org_x});
   assign h_oy  = C'({{16{head.org_y[15]}}, head.org_y});
   assign h_lim = C'({{16{head.limit[15]}}, head.limit});
   assign cx_e  = E'(cx_ff);
   assign w_e   = E'(head.width);
   assign lim_e = E'(lim_ff);
   assign reach = cx_e + w_e - E'(1);
   assign wrap  = !lim_ff[C-1] && (lim_ff != '0) && (reach > lim_e);
   assign px    = wrap ? lx_ff : cx_ff;
   assign py    = wrap ? cy_ff + C'(lh_ff) : cy_ff;

   always_comb begin
      lh_in        = csr_we ? csr_wdata : lh_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      lx_in        = lx_ff;
      lim_in       = lim_ff;
      pend_in      = pend_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      pend_code_in = pend_code_ff;
      rv_in        = rv_ff && !rsp_tready;
      rcode_in     = rcode_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rlast_in     = rlast_ff;
      q_pop        = 1'b0;
      if (pend_ff) begin
         if (out_ready) begin
            pend_in  = 1'b0;
            rv_in    = 1'b1;
            rcode_in = pend_code_ff;
            rx_in    = 16'(32'(pend_x_ff));
            ry_in    = 16'(32'(pend_y_ff));
            rlast_in = 1'b1;
         end
      end else if (!q_status.empty) begin
         unique case (head.kind)
            ptl_pkg::OP_START: begin
               q_pop  = 1'b1;
               lx_in  = h_ox;
               cx_in  = h_ox;
               cy_in  = h_oy;
               lim_in = h_lim;
            end
            ptl_pkg::OP_NEWLINE: begin
               q_pop = 1'b1;
               cx_in = lx_ff;
               cy_in = cy_ff + C'(lh_ff);
            end
            ptl_pkg::OP_GLYPH: begin
               if (out_ready) begin
                  q_pop        = 1'b1;
                  cx_in        = px + C'(head.width) - C'(1);
                  cy_in        = py;
                  rv_in        = 1'b1;
                  rcode_in     = head.code;
                  rx_in        = 16'(32'(px));
                  ry_in        = 16'(32'(py));
                  rlast_in     = !head.bold;
                  pend_in      = head.bold;
                  pend_x_in    = px;
                  pend_y_in    = py + C'(1);
                  pend_code_in = head.code;
               end
            end
            default: begin
               q_pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lh_ff   <= 8'd8;
         cx_ff   <= '0;
         cy_ff   <= '0;
         lx_ff   <= '0;
         lim_ff  <= '0;
         pend_ff <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         lh_ff   <= lh_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         lx_ff   <= lx_in;
         lim_ff  <= lim_in;
         pend_ff <= pend_in;
         rv_ff   <= rv_in;
      end
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      pend_code_ff <= pend_code_in;
      rcode_ff     <= rcode_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rlast_ff     <= rlast_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {ry_ff, rx_ff, rcode_ff};
   assign rsp_tlast  = rlast_ff;

endmodule

>>> hdl/proportional_text_layout.sv
// ============================================================================
// proportional_text_layout: proportional-font string to glyph placements
// Width writes load the glyph width table, a start request opens a string and
// character requests move the cursor or place glyphs, twice when bold.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  req_tdata, req_tuser
//   rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tlast
//   csr_      in         csr_we                 csr_wdata (line_height)
//
// One request is taken per cycle while req_tready is high. An accepted request
// passes through the width RAM read register and the queue entry, and the
// placement is worked out from the queue head into the result register. A bold
// glyph gives two results and holds the placement stage until the second is
// issued. Reset is synchronous and clears the width table valid bits at once.
// The four-entry queue lets requests flow while results stall; req_tready falls
// once the queue and the front stage together hold four.
//
module proportional_text_layout #(
   parameter int GLYPH_COUNT      = 256,
   parameter int MAX_STRING_CHARS = 256,
   parameter int COORD_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[7:0], glyph_width[15:8], origin_x[31:16], origin_y[47:32],
   // wrap_limit[63:48]
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // glyph_index[7:0], dest_x[23:8], dest_y[39:24]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic                  q_push;
   logic                  q_pop;
   ptl_pkg::q_entry_type  q_entry;
   ptl_pkg::q_entry_type  q_head;
   ptl_pkg::q_status_type q_status;

   ptl_front #(
      .GLYPH_COUNT     (GLYPH_COUNT),
      .MAX_STRING_CHARS(MAX_STRING_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   ptl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   ptl_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .head      (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full || q_pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue read while empty");

   a_bold_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tlast && (rsp_tdata[7:0] == $past(rsp_tdata[7:0])))
      else $error("bold placement not followed by its second placement");

endmodule

>>> tb/proportional_text_layout_checker.sv
// ============================================================================
// proportional_text_layout_checker: layout predictor and placement scoreboard
// Watches the request, result and CSR ports of the text layout block. Every
// accepted request updates a private copy of the width table, cursor, bold
// and string state and queues the placements it should cause. Every accepted
// result is compared field by field with the oldest queued placement.
// ============================================================================
module proportional_text_layout_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          placement_count
);

   localparam int MAX_CHARS = 256;

   typedef struct packed {
      logic [7:0]         glyph;
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic               last;
   } placement_type;

   placement_type      expected_placements[$];
   logic [7:0]         width_table [256];
   logic signed [15:0] cursor_x;
   logic signed [15:0] cursor_y;
   logic signed [15:0] line_start_x;
   logic signed [15:0] limit_x;
   logic               bold_on;
   logic               string_ended;
   int                 chars_seen;
   logic [7:0]         line_height;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] placement %0d: %s", $time, placement_count, what);
   endtask

   task automatic layout_request(input logic [1:0] kind, input logic [63:0] data);
      logic [7:0] code;
      int         glyph_w;
      code = data[7:0];
      case (kind)
         ptl_pkg::REQ_WRITE: begin
            width_table[code] = data[15:8];
         end
         ptl_pkg::REQ_START: begin
            line_start_x = data[31:16];
            cursor_x     = data[31:16];
            cursor_y     = data[47:32];
            limit_x      = data[63:48];
            bold_on      = 1'b0;
            string_ended = 1'b0;
            chars_seen   = 0;
         end
         ptl_pkg::REQ_CHAR: begin
            if (!string_ended) begin
               if (code == ptl_pkg::END_CODE) begin
                  string_ended = 1'b1;
               end else begin
                  chars_seen++;
                  if (chars_seen >= MAX_CHARS) string_ended = 1'b1;
                  if (code == ptl_pkg::LF_CODE) begin
                     cursor_x = line_start_x;
                     cursor_y = cursor_y + line_height;
                  end else if (code == ptl_pkg::BOLD_CODE) begin
                     bold_on = !bold_on;
                  end else if (code != ptl_pkg::SKIP_CODE) begin
                     glyph_w = width_table[code];
                     // The wrap test is exact, so it must not wrap at 16 bits.
                     if (limit_x > 0 && int'(cursor_x) + glyph_w - 1 > int'(limit_x)) begin
                        cursor_x = line_start_x;
                        cursor_y = cursor_y + line_height;
                     end
                     if (bold_on) begin
                        expected_placements.push_back('{code, cursor_x, cursor_y, 1'b0});
                        expected_placements.push_back('{code, cursor_x, cursor_y + 16'sd1,
                                                        1'b1});
                     end else begin
                        expected_placements.push_back('{code, cursor_x, cursor_y, 1'b1});
                     end
                     cursor_x = cursor_x + 16'(glyph_w - 1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_placement();
      placement_type want;
      placement_count++;
      if (expected_placements.size() == 0) begin
         report_mismatch("result arrived with no placement expected");
         return;
      end
      want = expected_placements.pop_front();
      if (rsp_tdata[7:0] != want.glyph)
         report_mismatch($sformatf("glyph_index %0d, expected %0d", rsp_tdata[7:0],
                                   want.glyph));
      if (rsp_tdata[23:8] != want.dest_x)
         report_mismatch($sformatf("dest_x %0d, expected %0d", $signed(rsp_tdata[23:8]),
                                   want.dest_x));
      if (rsp_tdata[39:24] != want.dest_y)
         report_mismatch($sformatf("dest_y %0d, expected %0d", $signed(rsp_tdata[39:24]),
                                   want.dest_y));
      if (rsp_tlast != want.last)
         report_mismatch($sformatf("last %0d, expected %0d", rsp_tlast, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 256; i++) width_table[i] = '0;
         cursor_x        = '0;
         cursor_y        = '0;
         line_start_x    = '0;
         limit_x         = '0;
         bold_on         = 1'b0;
         string_ended    = 1'b1;
         chars_seen      = 0;
         line_height     = 8'd8;
         mismatch_count  = 0;
         placement_count = 0;
         expected_placements.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_placement();
         if (req_tvalid && req_tready) layout_request(req_tuser, req_tdata);
         if (csr_we) line_height = csr_wdata;
      end
      pending_count = expected_placements.size();
   end

endmodule

>>> tb/proportional_text_layout_tb.sv
// ============================================================================
// proportional_text_layout_tb: stimulus and verdict for the text layout block
// Drives a directed set of width writes, strings and special characters, then
// random sentences with random flow control on both channels, and changes the
// line height between phases. A checker instance predicts and compares.
// ============================================================================
module proportional_text_layout_tb;

   localparam int         REQUEST_TARGET = 750;
   localparam logic [1:0] REQ_UNUSED     = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ptl_pkg::REQ_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = '0;

   int mismatch_count;
   int pending_count;
   int placement_count;
   int request_count = 0;
   int height_writes = 0;
   bit steady_flow   = 1'b0;

   always #10 clock = ~clock;

   proportional_text_layout u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   proportional_text_layout_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .placement_count (placement_count)
   );

   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 13);
   end

   function automatic bit take_gap();
      return !steady_flow && ($urandom_range(0, 99) < 13);
   endfunction

   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return ptl_pkg::LF_CODE;
      if (roll < 20) return ptl_pkg::BOLD_CODE;
      if (roll < 25) return ptl_pkg::SKIP_CODE;
      if (roll < 30) return 8'($urandom);
      return 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] pick_width();
      if ($urandom_range(0, 99) < 80) return 8'($urandom_range(1, 12));
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 16'($urandom_range(0, 400) - 200);
      if (roll < 90) return 16'($urandom);
      if (roll < 95) return 16'(32767 - $urandom_range(0, 20));
      return 16'(32'h8000 + $urandom_range(0, 20));
   endfunction

   function automatic logic [15:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 16'(0 - $urandom_range(0, 300));
      if (roll < 85) return 16'($urandom_range(1, 400));
      return 16'($urandom);
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [7:0] code,
                               input logic [7:0] width, input logic [15:0] org_x,
                               input logic [15:0] org_y, input logic [15:0] limit);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {limit, org_y, org_x, width, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
      @(negedge clock);
   endtask

   task automatic write_width(input logic [7:0] code, input logic [7:0] width);
      send_request(ptl_pkg::REQ_WRITE, code, width, 16'($urandom), 16'($urandom),
                   16'($urandom));
   endtask

   task automatic start_string(input logic [15:0] org_x, input logic [15:0] org_y,
                               input logic [15:0] limit);
      send_request(ptl_pkg::REQ_START, 8'($urandom), 8'($urandom), org_x, org_y, limit);
   endtask

   task automatic send_char(input logic [7:0] code);
      send_request(ptl_pkg::REQ_CHAR, code, 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
   endtask

   task automatic set_line_height(input logic [7:0] height);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= height;
      @(negedge clock);
      csr_we <= 1'b0;
      height_writes++;
   endtask

   task automatic send_sentence();
      int writes;
      int length;
      writes = $urandom_range(0, 3);
      repeat (writes) write_width(pick_char(), pick_width());
      start_string(pick_coord(), pick_coord(), pick_limit());
      length = $urandom_range(1, 30);
      repeat (length) send_char(pick_char());
      if ($urandom_range(0, 9) != 0) send_char(ptl_pkg::END_CODE);
   endtask

   initial begin
      bit long_done;
      int next_height_at;
      long_done      = 1'b0;
      next_height_at = 150;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_char("A");
      send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      write_width("A", 8'd5);
      write_width("W", 8'd255);
      write_width("i", 8'd0);
      write_width(8'hFF, 8'd1);
      start_string(16'h8000, 16'h7FFF, 16'd0);
      send_char("A");
      send_char(ptl_pkg::BOLD_CODE);
      send_char("W");
      send_char(ptl_pkg::BOLD_CODE);
      send_char(ptl_pkg::SKIP_CODE);
      send_char(ptl_pkg::LF_CODE);
      send_char(8'hFF);
      send_char("i");
      send_char(ptl_pkg::END_CODE);
      send_char("A");
      start_string(16'd32700, 16'd32760, 16'd32767);
      send_char("W");
      send_char("W");
      send_char(ptl_pkg::BOLD_CODE);
      send_char("W");
      write_width("q", 8'd3);
      send_char("q");
      start_string(16'd10, 16'hFFFB, 16'hFFFF);
      send_char("A");

      set_line_height(8'd0);
      start_string(16'd0, 16'd0, 16'd12);
      repeat (6) send_char("A");
      send_char(ptl_pkg::LF_CODE);
      set_line_height(8'd255);
      start_string(16'd0, 16'd32700, 16'd12);
      repeat (6) send_char("A");
      send_char(ptl_pkg::LF_CODE);
      send_char("A");

      for (int c = 32; c < 127; c++) write_width(8'(c), pick_width());

      while (request_count < REQUEST_TARGET) begin
         steady_flow = (request_count >= 300 && request_count < 420);
         if (request_count >= next_height_at) begin
            case ($urandom_range(0, 2))
               0:       set_line_height(8'd255);
               1:       set_line_height(8'd0);
               default: set_line_height(8'($urandom));
            endcase
            next_height_at += 150;
         end
         if (!long_done && request_count >= 480) begin
            start_string(16'd0, 16'd0, 16'd200);
            repeat (270) send_char(8'($urandom_range(32, 126)));
            send_char(ptl_pkg::END_CODE);
            long_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_sentence();
         end
      end
      steady_flow = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Run covered %0d requests and %0d checked glyph placements.", request_count,
               placement_count);
      $display("Line height was rewritten %0d times, both extremes included.",
               height_writes);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d placements still expected.", pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
hdl/ptl_pkg.sv
hdl/ptl_ram.sv
hdl/ptl_front.sv
hdl/ptl_queue.sv
hdl/ptl_back.sv
hdl/proportional_text_layout.sv
tb/proportional_text_layout_checker.sv
tb/proportional_text_layout_tb.sv
